>>> sv/pzf_pkg.sv
// Package: shared types and constants of the pan/zoom follower.
package pzf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int MAG_EPS = (1 << ANGLE_FRAC_BITS) / 1000000;
  localparam int ANG_W = 20;
  localparam int FOV_W = 16;
  localparam int CFG_W = 20;
  localparam int IDX_W = 3;
  localparam int ROOT_W = 21;
  localparam int CNT_W = 5;
  localparam int ITER_LAST = ROOT_W - 1;

  localparam int GAIN_MIN = 66;
  localparam int GAIN_ONE = 65536;
  localparam int REACT_MIN = 256;
  localparam int REACT_MAX = 2560;
  localparam int FOV_MIN = 256;
  localparam int FOV_MAX = 46080;
  localparam int ANG_MIN = -524288;
  localparam int ANG_MAX = 524287;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_STEP,
    REG_VEL_GAIN,
    REG_REACT,
    REG_DEAD_ZONE,
    REG_ZOOM_GAIN,
    REG_ZOOM_RESET,
    REG_PITCH_LOCK,
    REG_LOCKED_PITCH
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_MAXV,
    OP_MUL_VA,
    OP_MUL_SQY,
    OP_MUL_SQP,
    OP_SQ_SUM,
    OP_SQRT,
    OP_MUL_SY,
    OP_DIV_INIT,
    OP_DIV,
    OP_FIX_Y,
    OP_FIX_P,
    OP_CLAMP,
    OP_MUL_EY,
    OP_MUL_EP,
    OP_MUL_Z,
    OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAXV,
    ST_VA,
    ST_SQY,
    ST_SQP,
    ST_SUM,
    ST_SQRT,
    ST_SY,
    ST_DIVY0,
    ST_DIVY,
    ST_FIXY,
    ST_DIVP0,
    ST_DIVP,
    ST_FIXP,
    ST_CLAMP,
    ST_EY,
    ST_EP,
    ST_Z,
    ST_FIN
  } st_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic aim;
    logic dz_on;
    logic mag_ok;
  } sts_t;

endpackage

>>> sv/pzf_if.sv
// Interfaces: aim request channel and view result channel.
interface pzf_aim_if;
  logic valid;
  logic ready;
  logic signed [19:0] aim_yaw;
  logic signed [19:0] aim_pitch;
  logic aim_valid;
  logic [15:0] zoom_aim;
  logic zoom_valid;
  modport source (output valid, aim_yaw, aim_pitch, aim_valid, zoom_aim, zoom_valid,
                  input ready);
  modport sink (input valid, aim_yaw, aim_pitch, aim_valid, zoom_aim, zoom_valid,
                output ready);
endinterface

interface pzf_view_if;
  logic valid;
  logic ready;
  logic signed [19:0] view_yaw;
  logic signed [19:0] view_pitch;
  logic [15:0] view_fov;
  modport source (output valid, view_yaw, view_pitch, view_fov, input ready);
  modport sink (input valid, view_yaw, view_pitch, view_fov, output ready);
endinterface

>>> sv/pzf_ctrl.sv
// Controller: sequences the datapath through one request.
module pzf_ctrl
  import pzf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = OP_NONE;
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = ST_MAXV;
        end
      end
      ST_MAXV: begin
        cmd.op = OP_MUL_MAXV;
        state_next = sts.aim ? ST_VA : ST_Z;
      end
      ST_VA: begin
        cmd.op = OP_MUL_VA;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op = OP_MUL_SQY;
        state_next = sts.dz_on ? ST_SQP : ST_CLAMP;
      end
      ST_SQP: begin
        cmd.op = OP_MUL_SQP;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = OP_SQ_SUM;
        cnt_next = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(ITER_LAST)) begin
          cnt_next = '0;
          state_next = ST_SY;
        end
      end
      ST_SY: begin
        cmd.op = OP_MUL_SY;
        state_next = sts.mag_ok ? ST_DIVY0 : ST_CLAMP;
      end
      ST_DIVY0: begin
        cmd.op = OP_DIV_INIT;
        state_next = ST_DIVY;
      end
      ST_DIVY: begin
        cmd.op = OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(ITER_LAST)) begin
          cnt_next = '0;
          state_next = ST_FIXY;
        end
      end
      ST_FIXY: begin
        cmd.op = OP_FIX_Y;
        state_next = ST_DIVP0;
      end
      ST_DIVP0: begin
        cmd.op = OP_DIV_INIT;
        state_next = ST_DIVP;
      end
      ST_DIVP: begin
        cmd.op = OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(ITER_LAST)) begin
          cnt_next = '0;
          state_next = ST_FIXP;
        end
      end
      ST_FIXP: begin
        cmd.op = OP_FIX_P;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op = OP_CLAMP;
        state_next = ST_EY;
      end
      ST_EY: begin
        cmd.op = OP_MUL_EY;
        state_next = ST_EP;
      end
      ST_EP: begin
        cmd.op = OP_MUL_EP;
        state_next = ST_Z;
      end
      ST_Z: begin
        cmd.op = OP_MUL_Z;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op = OP_FIN;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN)) else $error("result without finish");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ITER_LAST)) else $error("iteration count overrun");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN) |=> (state == ST_IDLE && out_valid)) else $error("finish slip");
`endif

endmodule

>>> sv/pzf_dp.sv
// Datapath: registers, shared multiplier, square root and divider steps.
module pzf_dp
  import pzf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic signed [ANG_W-1:0] aim_yaw,
  input  logic signed [ANG_W-1:0] aim_pitch,
  input  logic aim_valid,
  input  logic [FOV_W-1:0] zoom_aim,
  input  logic zoom_valid,
  output logic signed [ANG_W-1:0] pose_yaw,
  output logic signed [ANG_W-1:0] pose_pitch,
  output logic [FOV_W-1:0] fov_now
);

  logic [16:0] max_step, vel_gain, zoom_gain;
  logic [11:0] react;
  logic [18:0] dead_zone;
  logic pitch_lock;
  logic signed [ANG_W-1:0] locked_pitch;

  logic signed [ANG_W-1:0] speed_yaw, speed_pitch;
  logic aim_r, zoom_r;
  logic [FOV_W-1:0] za;
  logic signed [20:0] ey, ep;
  logic [20:0] maxv;
  logic [16:0] valpha;
  logic [41:0] sq, sqx;
  logic [22:0] sr;
  logic [ROOT_W-1:0] root, remv;
  logic [21:0] drem;
  logic [20:0] dlow;
  logic signed [49:0] prod;
  logic signed [24:0] mul_a, mul_b;

  logic [11:0] react_c;
  logic [16:0] vg_c, zg_c;
  logic [FOV_W-1:0] za_c, zr_c;
  logic [20:0] abs_ey, abs_ep, va_raw;
  logic [ROOT_W-1:0] remv_c;
  logic signed [22:0] d_y, d_p, ey_x, ep_x, mx;
  logic signed [20:0] tp;
  logic signed [23:0] rnd;
  logic [24:0] sq_t, sq_trial;
  logic [42:0] div_d;
  logic [21:0] div_t;

  function automatic logic [16:0] clamp_gain(input logic [16:0] g);
    clamp_gain = (g < 17'(GAIN_MIN)) ? 17'(GAIN_MIN) :
                 ((g > 17'(GAIN_ONE)) ? 17'(GAIN_ONE) : g);
  endfunction

  function automatic logic [FOV_W-1:0] clamp_fov(input logic [FOV_W-1:0] f);
    clamp_fov = (f < FOV_W'(FOV_MIN)) ? FOV_W'(FOV_MIN) :
                ((f > FOV_W'(FOV_MAX)) ? FOV_W'(FOV_MAX) : f);
  endfunction

  function automatic logic signed [23:0] rnd16(input logic signed [49:0] p);
    logic [49:0] m;
    logic [49:0] s;
    m = p[49] ? 50'(-p) : 50'(p);
    s = m + 50'd32768;
    rnd16 = p[49] ? -$signed(s[39:16]) : $signed(s[39:16]);
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [24:0] v);
    sat_ang = (v > 25'(ANG_MAX)) ? ANG_W'(ANG_MAX) :
              ((v < 25'(ANG_MIN)) ? ANG_W'(ANG_MIN) : v[ANG_W-1:0]);
  endfunction

  function automatic logic signed [20:0] clamp_err(input logic signed [22:0] e,
                                                   input logic signed [22:0] m);
    clamp_err = (e > m) ? m[20:0] : ((e < -m) ? 21'(-m) : e[20:0]);
  endfunction

  assign react_c = (react < 12'(REACT_MIN)) ? 12'(REACT_MIN) :
                   ((react > 12'(REACT_MAX)) ? 12'(REACT_MAX) : react);
  assign vg_c = clamp_gain(vel_gain);
  assign zg_c = clamp_gain(zoom_gain);
  assign za_c = clamp_fov(zoom_aim);
  assign zr_c = clamp_fov(cfg_data[FOV_W-1:0]);
  assign abs_ey = ey[20] ? 21'(-ey) : 21'(ey);
  assign abs_ep = ep[20] ? 21'(-ep) : 21'(ep);
  assign remv_c = (root > ROOT_W'(dead_zone)) ? root - ROOT_W'(dead_zone) : '0;
  assign d_y = 23'(ey) - 23'(speed_yaw);
  assign d_p = 23'(ep) - 23'(speed_pitch);
  assign ey_x = 23'(ey);
  assign ep_x = 23'(ep);
  assign mx = $signed({2'b00, maxv});
  assign tp = pitch_lock ? 21'(locked_pitch) : 21'(aim_pitch);
  assign rnd = rnd16(prod);
  assign va_raw = prod[28:8];
  assign sq_t = {sr, sqx[41:40]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign div_d = 43'(prod[41:0]) + 43'(root[ROOT_W-1:1]);
  assign div_t = {drem[20:0], dlow[20]};

  assign sts.aim = aim_r;
  assign sts.dz_on = (dead_zone != '0);
  assign sts.mag_ok = (root > ROOT_W'(MAG_EPS)) && (root != '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_MAXV: begin
        mul_a = $signed({8'd0, max_step});
        mul_b = $signed({13'd0, react_c});
      end
      OP_MUL_VA: begin
        mul_a = $signed({8'd0, vg_c});
        mul_b = $signed({13'd0, react_c});
      end
      OP_MUL_SQY: begin
        mul_a = 25'(ey);
        mul_b = 25'(ey);
      end
      OP_MUL_SQP: begin
        mul_a = 25'(ep);
        mul_b = 25'(ep);
      end
      OP_MUL_SY: begin
        mul_a = $signed({4'd0, abs_ey});
        mul_b = $signed({4'd0, remv_c});
      end
      OP_FIX_Y: begin
        mul_a = $signed({4'd0, abs_ep});
        mul_b = $signed({4'd0, remv});
      end
      OP_MUL_EY: begin
        mul_a = $signed({8'd0, valpha});
        mul_b = 25'(d_y);
      end
      OP_MUL_EP: begin
        mul_a = $signed({8'd0, valpha});
        mul_b = 25'(d_p);
      end
      OP_MUL_Z: begin
        mul_a = $signed({8'd0, zg_c});
        mul_b = $signed({9'd0, za}) - $signed({9'd0, fov_now});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product holds while the finish step waits on the output
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= 17'd3277;
      vel_gain <= 17'd13107;
      react <= 12'd256;
      dead_zone <= '0;
      zoom_gain <= 17'd6554;
      pitch_lock <= 1'b0;
      locked_pitch <= '0;
      fov_now <= 16'd8704;
      pose_yaw <= '0;
      pose_pitch <= '0;
      speed_yaw <= '0;
      speed_pitch <= '0;
      aim_r <= 1'b0;
      zoom_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_STEP:     max_step <= cfg_data[16:0];
          REG_VEL_GAIN:     vel_gain <= cfg_data[16:0];
          REG_REACT:        react <= cfg_data[11:0];
          REG_DEAD_ZONE:    dead_zone <= cfg_data[18:0];
          REG_ZOOM_GAIN:    zoom_gain <= cfg_data[16:0];
          REG_ZOOM_RESET:   fov_now <= zr_c;
          REG_PITCH_LOCK:   pitch_lock <= cfg_data[0];
          REG_LOCKED_PITCH: locked_pitch <= cfg_data;
          default: begin
          end
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          aim_r <= aim_valid;
          zoom_r <= zoom_valid;
        end
        OP_MUL_EP: speed_yaw <= sat_ang(25'(speed_yaw) + 25'(rnd));
        OP_MUL_Z: begin
          if (aim_r) begin
            speed_pitch <= sat_ang(25'(speed_pitch) + 25'(rnd));
          end
        end
        OP_FIN: begin
          if (aim_r) begin
            pose_yaw <= sat_ang(25'(pose_yaw) + 25'(speed_yaw));
            pose_pitch <= sat_ang(25'(pose_pitch) + 25'(speed_pitch));
          end
          if (zoom_r) begin
            fov_now <= ((25'(fov_now) + 25'(rnd)) < 25'(FOV_MIN)) ? FOV_W'(FOV_MIN) :
                       (((25'(fov_now) + 25'(rnd)) > 25'(FOV_MAX)) ? FOV_W'(FOV_MAX) :
                        FOV_W'(25'(fov_now) + 25'(rnd)));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        za <= za_c;
        ey <= 21'(aim_yaw) - 21'(pose_yaw);
        ep <= tp - 21'(pose_pitch);
      end
      OP_MUL_VA: maxv <= prod[28:8];
      OP_MUL_SQY: valpha <= (va_raw > 21'(GAIN_ONE)) ? 17'(GAIN_ONE) : va_raw[16:0];
      OP_MUL_SQP: sq <= prod[41:0];
      OP_SQ_SUM: begin
        sqx <= sq + prod[41:0];
        sr <= '0;
        root <= '0;
      end
      OP_SQRT: begin
        if (sq_t >= sq_trial) begin
          sr <= 23'(sq_t - sq_trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          sr <= sq_t[22:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sqx <= {sqx[39:0], 2'b00};
      end
      OP_MUL_SY: remv <= remv_c;
      OP_DIV_INIT: begin
        drem <= div_d[42:21];
        dlow <= div_d[20:0];
      end
      OP_DIV: begin
        if (div_t >= {1'b0, root}) begin
          drem <= div_t - {1'b0, root};
          dlow <= {dlow[19:0], 1'b1};
        end else begin
          drem <= div_t;
          dlow <= {dlow[19:0], 1'b0};
        end
      end
      OP_FIX_Y: ey <= ey[20] ? -$signed(dlow) : $signed(dlow);
      OP_FIX_P: ep <= ep[20] ? -$signed(dlow) : $signed(dlow);
      OP_CLAMP: begin
        ey <= clamp_err(ey_x, mx);
        ep <= clamp_err(ep_x, mx);
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV) |-> (root != '0)) else $error("divide by zero magnitude");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV) |-> (drem < 22'(root))) else $error("divider remainder overflow");
  a_fov_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op == OP_FIN) |-> (fov_now >= FOV_W'(FOV_MIN) && fov_now <= FOV_W'(FOV_MAX)))
    else $error("fov out of range");
`endif

endmodule

>>> sv/pan_zoom_follower_core.sv
// Top level: pan/zoom follower, controller plus datapath.
// Paths from accept to result valid: no aim, aim with dead zone off, dead zone on
// (21-step square root, two 21-step divides), and dead zone on with zero error.
// One request at a time, accepted in the cycle after the previous finish;
// finish stalls while the previous result is still waiting in the output register.
// Synchronous active-high reset: registers to defaults, pose and speed zero, fov 8704.
module pan_zoom_follower_core
  import pzf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pzf_aim_if.sink aim,
  pzf_view_if.source view,
  input  logic cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  pzf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (aim.valid),
    .in_ready  (aim.ready),
    .out_valid (view.valid),
    .out_ready (view.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pzf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .aim_yaw    (aim.aim_yaw),
    .aim_pitch  (aim.aim_pitch),
    .aim_valid  (aim.aim_valid),
    .zoom_aim   (aim.zoom_aim),
    .zoom_valid (aim.zoom_valid),
    .pose_yaw   (view.view_yaw),
    .pose_pitch (view.view_pitch),
    .fov_now    (view.view_fov)
  );

endmodule

>>> test/pan_zoom_follower_core_test.sv
// Testbench: pan/zoom follower core, directed table, register extremes, then random requests, checked by a predictor.
module pan_zoom_follower_core_test;
  import pzf_pkg::*;

  typedef struct {
    logic signed [19:0] yaw;
    logic signed [19:0] pitch;
    logic aim_on;
    logic [15:0] zoom;
    logic zoom_on;
  } aim_req_t;

  typedef struct {
    logic signed [19:0] yaw;
    logic signed [19:0] pitch;
    logic [15:0] fov;
  } view_t;

  typedef struct {
    aim_req_t req;
    logic typed;
    view_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pzf_aim_if aim ();
  pzf_view_if view ();

  pan_zoom_follower_core u_top (
    .clk(clk), .rst(rst), .aim(aim.sink), .view(view.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  longint regs [8];
  longint pose_y, pose_p, spd_y, spd_p, fov_cur;
  view_t pending_views [$];
  int errors = 0;
  int calm = 0;
  int hold_off = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rnd16(longint n);
    longint m;
    m = n < 0 ? -n : n;
    m = (m + 32768) >>> 16;
    return n < 0 ? -m : m;
  endfunction

  function automatic longint root(longint x);
    longint r, b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint shrink(longint e, longint num, longint den);
    longint m;
    m = e < 0 ? -e : e;
    m = (m * num + den / 2) / den;
    return e < 0 ? -m : m;
  endfunction

  function automatic longint sx20(longint v);
    v = v & 64'hFFFFF;
    return v[19] ? v - 1048576 : v;
  endfunction

  function automatic void write_reg_model(int idx, longint val);
    int w [8] = '{17, 17, 12, 19, 17, 16, 1, 20};
    regs[idx] = val & ((64'sd1 <<< w[idx]) - 1);
    if (idx == REG_ZOOM_RESET) fov_cur = clip(regs[idx], FOV_MIN, FOV_MAX);
  endfunction

  function automatic view_t follow_step(aim_req_t r);
    longint react, ty, tp, maxv, vg, va, ey, ep, dz, mag, rem, zg, za;
    view_t v;
    react = clip(regs[REG_REACT], REACT_MIN, REACT_MAX);
    if (r.aim_on) begin
      ty = r.yaw;
      tp = regs[REG_PITCH_LOCK][0] ? sx20(regs[REG_LOCKED_PITCH]) : longint'(r.pitch);
      maxv = (regs[REG_MAX_STEP] * react) >>> 8;
      vg = clip(regs[REG_VEL_GAIN], GAIN_MIN, GAIN_ONE);
      va = (vg * react) >>> 8;
      if (va > GAIN_ONE) va = GAIN_ONE;
      ey = ty - pose_y;
      ep = tp - pose_p;
      dz = regs[REG_DEAD_ZONE];
      if (dz > 0) begin
        mag = root(ey * ey + ep * ep);
        if (mag > MAG_EPS && mag > 0) begin
          rem = mag > dz ? mag - dz : 0;
          ey = shrink(ey, rem, mag);
          ep = shrink(ep, rem, mag);
        end
      end
      ey = clip(ey, -maxv, maxv);
      ep = clip(ep, -maxv, maxv);
      spd_y = clip(spd_y + rnd16(va * (ey - spd_y)), ANG_MIN, ANG_MAX);
      spd_p = clip(spd_p + rnd16(va * (ep - spd_p)), ANG_MIN, ANG_MAX);
      pose_y = clip(pose_y + spd_y, ANG_MIN, ANG_MAX);
      pose_p = clip(pose_p + spd_p, ANG_MIN, ANG_MAX);
    end
    if (r.zoom_on) begin
      zg = clip(regs[REG_ZOOM_GAIN], GAIN_MIN, GAIN_ONE);
      za = clip(longint'(r.zoom), FOV_MIN, FOV_MAX);
      fov_cur = clip(fov_cur + rnd16(zg * (za - fov_cur)), FOV_MIN, FOV_MAX);
    end
    v.yaw = pose_y[19:0];
    v.pitch = pose_p[19:0];
    v.fov = fov_cur[15:0];
    return v;
  endfunction

  function automatic int idle_roll();
    if (calm > 0) return 0;
    return $urandom_range(99) < 14;
  endfunction

  task automatic write_reg(reg_idx_t idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    write_reg_model(idx, val);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    aim.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send(aim_req_t r, logic typed, view_t want);
    view_t v;
    view_t e;
    while (idle_roll()) begin
      aim.valid <= 1'b0;
      @(posedge clk);
    end
    aim.valid <= 1'b1;
    aim.aim_yaw <= r.yaw;
    aim.aim_pitch <= r.pitch;
    aim.aim_valid <= r.aim_on;
    aim.zoom_aim <= r.zoom;
    aim.zoom_valid <= r.zoom_on;
    @(posedge clk);
    while (!aim.ready) @(posedge clk);
    v = follow_step(r);
    if (typed) begin
      if (v.yaw != want.yaw) begin
        $error("table view_yaw expected %0d actual %0d", want.yaw, v.yaw);
        errors++;
      end
      if (v.pitch != want.pitch) begin
        $error("table view_pitch expected %0d actual %0d", want.pitch, v.pitch);
        errors++;
      end
      if (v.fov != want.fov) begin
        $error("table view_fov expected %0d actual %0d", want.fov, v.fov);
        errors++;
      end
      e = want;
    end else begin
      e = v;
    end
    pending_views = {pending_views, e};
  endtask

  function automatic aim_req_t rand_req();
    aim_req_t r;
    int mode;
    mode = $urandom_range(9);
    r.yaw = 20'($urandom);
    r.pitch = 20'($urandom);
    if (mode < 6) begin
      r.yaw = 20'(int'($urandom_range(0, 40000)) - 20000);
      r.pitch = 20'(int'($urandom_range(0, 40000)) - 20000);
    end
    r.aim_on = $urandom_range(9) != 0;
    r.zoom = 16'($urandom);
    if (mode < 7) r.zoom = 16'($urandom_range(FOV_MIN, FOV_MAX));
    r.zoom_on = $urandom_range(3) != 0;
    return r;
  endfunction

  function automatic aim_req_t mk(longint y, longint p, logic a, longint z, logic zv);
    aim_req_t r;
    r.yaw = y[19:0];
    r.pitch = p[19:0];
    r.aim_on = a;
    r.zoom = z[15:0];
    r.zoom_on = zv;
    return r;
  endfunction

  function automatic view_t vw(longint y, longint p, longint f);
    view_t v;
    v.yaw = y[19:0];
    v.pitch = p[19:0];
    v.fov = f[15:0];
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    view_t w;
    if (!rst && view.valid && view.ready) begin
      if (pending_views.size() == 0) begin
        $error("view result with no request outstanding");
        errors++;
      end else begin
        w = pending_views.pop_front();
        if (view.view_yaw !== w.yaw) begin
          $error("view_yaw expected %0d actual %0d", w.yaw, view.view_yaw);
          errors++;
        end
        if (view.view_pitch !== w.pitch) begin
          $error("view_pitch expected %0d actual %0d", w.pitch, view.view_pitch);
          errors++;
        end
        if (view.view_fov !== w.fov) begin
          $error("view_fov expected %0d actual %0d", w.fov, view.view_fov);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      view.ready <= 1'b0;
    end else begin
      view.ready <= !idle_roll();
    end
  end

  initial begin
    #20_000_000;
    $display("pan_zoom_follower_core verification failed");
    $finish;
  end

  initial begin
    row_t rows [$];
    view_t none;
    aim_req_t r;
    int n;
    aim.valid = 1'b0;
    aim.aim_yaw = '0;
    aim.aim_pitch = '0;
    aim.aim_valid = 1'b0;
    aim.zoom_aim = '0;
    aim.zoom_valid = 1'b0;
    view.ready = 1'b0;
    none = vw(0, 0, 0);
    regs = '{3277, 13107, 256, 0, 6554, 8704, 0, 0};
    pose_y = 0; pose_p = 0; spd_y = 0; spd_p = 0; fov_cur = 8704;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    rows = {rows, row_t'{mk(0, 0, 0, 0, 0), 1'b1, vw(0, 0, 8704)}};
    rows = {rows, row_t'{mk(123, -77, 0, 46080, 0), 1'b1, vw(0, 0, 8704)}};
    rows = {rows, row_t'{mk(0, 0, 1, 8704, 1), 1'b1, vw(0, 0, 8704)}};
    rows = {rows, row_t'{mk(ANG_MAX, ANG_MIN, 1, 65535, 1), 1'b0, none}};
    rows = {rows, row_t'{mk(ANG_MIN, ANG_MAX, 1, 0, 1), 1'b0, none}};
    rows = {rows, row_t'{mk(ANG_MAX, ANG_MAX, 1, 256, 1), 1'b0, none}};
    rows = {rows, row_t'{mk(-1, 1, 1, 46080, 1), 1'b0, none}};
    rows = {rows, row_t'{mk(1000, -1000, 0, 255, 1), 1'b0, none}};
    rows = {rows, row_t'{mk(0, 0, 1, 46081, 0), 1'b0, none}};
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].want);
    wait_drained();

    // extremes of the register ranges, incl. out-of-range gains
    write_reg(REG_MAX_STEP, 65536);
    write_reg(REG_VEL_GAIN, 0);
    write_reg(REG_REACT, 4095);
    write_reg(REG_DEAD_ZONE, 524287);
    write_reg(REG_ZOOM_GAIN, 131071);
    write_reg(REG_ZOOM_RESET, 65535);
    write_reg(REG_PITCH_LOCK, 1);
    write_reg(REG_LOCKED_PITCH, 20'h80000);
    write_reg(REG_LOCKED_PITCH, 524287);
    for (int i = 0; i < 6; i++) send(mk(ANG_MAX - i, i, 1, i * 9000, 1), 1'b0, none);
    wait_drained();
    write_reg(REG_DEAD_ZONE, 1);
    write_reg(REG_ZOOM_RESET, 0);
    write_reg(REG_REACT, 0);
    write_reg(REG_VEL_GAIN, 131071);
    write_reg(REG_ZOOM_GAIN, 0);
    write_reg(REG_MAX_STEP, 0);
    for (int i = 0; i < 4; i++) send(mk(-i * 5000, i * 7000, 1, 300, 1), 1'b0, none);
    wait_drained();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAX_STEP, $urandom_range(0, 65536));
      write_reg(REG_VEL_GAIN, ph == 0 ? 65536 : $urandom_range(0, 131071));
      write_reg(REG_REACT, ph == 1 ? 2560 : $urandom_range(0, 4095));
      write_reg(REG_DEAD_ZONE, ph % 2 ? $urandom_range(0, 524287) >> $urandom_range(0, 12) : 0);
      write_reg(REG_ZOOM_GAIN, $urandom_range(0, 131071));
      write_reg(REG_ZOOM_RESET, $urandom_range(0, 65535));
      write_reg(REG_PITCH_LOCK, ph == 3);
      write_reg(REG_LOCKED_PITCH, $urandom);
      n = 72;
      for (int k = 0; k < n; k++) begin
        if (ph == 2 && k == 10) hold_off = 400;
        if (ph == 4 && k == 0) calm = 1;
        if (ph == 4 && k == 50) calm = 0;
        r = rand_req();
        send(r, 1'b0, none);
      end
      wait_drained();
    end

    n = 0;
    while (pending_views.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_views.size() == 0)
      $display("pan_zoom_follower_core verification clean");
    else
      $display("pan_zoom_follower_core verification failed");
    $finish;
  end

endmodule
